### rtl/affine_texel_span_generator_unit_assert.svh
// Assertion macros for the affine texel span generator, clocked on clk and disabled in reset.
`ifndef AFFINE_TEXEL_SPAN_GENERATOR_UNIT_ASSERT_SVH
`define AFFINE_TEXEL_SPAN_GENERATOR_UNIT_ASSERT_SVH

`ifndef NO_ASSERTIONS
// A condition that must hold at every clock edge outside reset.
`define ATSG_ASSERT(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);
// A condition that must hold in the cycle after the trigger.
`define ATSG_ASSERT_NEXT(lbl, trig, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (trig) |=> (cond)) \
		else $error(msg);
`else
`define ATSG_ASSERT(lbl, cond, msg)
`define ATSG_ASSERT_NEXT(lbl, trig, cond, msg)
`endif

`endif

### rtl/atsg_pkg.sv
// Package with the constants, register codes and helper functions of the texel span generator.
package atsg_pkg;

	localparam int FRAC_BITS = 24;
	localparam int PT_W      = 48;
	localparam int PROD_W    = PT_W + 1;
	localparam int T_W       = FRAC_BITS + 1;
	localparam int SIZE_W    = 13;
	localparam int TP_W      = T_W + SIZE_W;
	localparam int IDX_W     = 12;
	localparam int CNT_W     = 7;
	localparam int MAX_RUN   = 64;
	localparam int MAX_DIM   = 4096;

	localparam logic [T_W-1:0] ONE_FX = T_W'(1) << FRAC_BITS;
	localparam logic [T_W:0]   TWO_FX = (T_W + 1)'(1) << (FRAC_BITS + 1);

	localparam logic [1:0] TILE_CLAMP  = 2'd0;
	localparam logic [1:0] TILE_REPEAT = 2'd1;
	localparam logic [1:0] TILE_MIRROR = 2'd2;

	localparam logic [2:0] REG_COEF_A  = 3'd0;
	localparam logic [2:0] REG_COEF_B  = 3'd1;
	localparam logic [2:0] REG_COEF_C  = 3'd2;
	localparam logic [2:0] REG_COEF_D  = 3'd3;
	localparam logic [2:0] REG_COEF_E  = 3'd4;
	localparam logic [2:0] REG_COEF_F  = 3'd5;
	localparam logic [2:0] REG_TEXSIZE = 3'd6;
	localparam logic [2:0] REG_TILE    = 3'd7;

	localparam logic [31:0] TEXSIZE_RESET = 32'h0001_0001;

	// Zero becomes one, anything above the largest texture dimension is held there.
	function automatic logic [SIZE_W-1:0] fix_size(input logic [15:0] s);
		logic [SIZE_W-1:0] r;
		if (s == 16'd0) begin
			r = SIZE_W'(1);
		end else if (s > 16'(MAX_DIM)) begin
			r = SIZE_W'(MAX_DIM);
		end else begin
			r = s[SIZE_W-1:0];
		end
		return r;
	endfunction

	// Folds a point into [0, 1.0] by clamp, repeat or mirror; mode 3 acts as mirror.
	function automatic logic [T_W-1:0] tile_point(input logic [PT_W-1:0] p,
			input logic [1:0] mode);
		logic [T_W:0]   m;
		logic [T_W-1:0] t;
		m = {1'b0, p[T_W-1:0]};
		t = '0;
		unique case (mode)
			TILE_CLAMP: begin
				if (p[PT_W-1]) begin
					t = '0;
				end else if (p > PT_W'(ONE_FX)) begin
					t = ONE_FX;
				end else begin
					t = p[T_W-1:0];
				end
			end
			TILE_REPEAT: begin
				t = {1'b0, p[FRAC_BITS-1:0]};
			end
			default: begin
				if (m > (T_W + 1)'(ONE_FX)) begin
					t = T_W'(TWO_FX - m);
				end else begin
					t = m[T_W-1:0];
				end
			end
		endcase
		return t;
	endfunction

endpackage

### rtl/affine_texel_span_generator_unit.sv
// Affine texel span generator: top level. A span request (start_x, row_y, pixel_count) has
// its first pixel center mapped through the configured inverse affine matrix, which
// takes three pipeline stages (capture, four 48x17 products, sum), and then enters the
// span generator, which emits one point per cycle while stage 4 can take it and steps
// it by (coef_a, coef_d). Each point runs through three more stages (tiling, scaling
// by the texture size, flooring and limiting to size-1) into the output register. A
// span occupies the span generator for one point per pixel (counts above 64 are cut
// to 64, a count of zero gives no texel), and the generator is what sets the rate:
// one texel per cycle while the output does not stall. The next span's start point is
// computed in the front stages while the current span is emitted, so spans follow each
// other without gaps. Every stage holds its content while the stage after it is full
// and stalled, so back pressure on the output loses and repeats nothing. Configuration
// is by APB at byte address 8*i for register i; it must only be written while no span
// is in flight.
`include "affine_texel_span_generator_unit_assert.svh"

module affine_texel_span_generator_unit
	import atsg_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	// Configuration port.
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [5:0]  paddr,
	input  logic [63:0] pwdata,
	output logic [63:0] prdata,
	output logic        pready,
	// Span requests.
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,   // start_x [15:0], row_y [31:16], pixel_count [38:32]
	// Texel coordinates.
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,   // texel_col [11:0], texel_row [23:12]
	output logic        m_tlast
);

	// Configuration registers.
	logic [PT_W-1:0] coef_a_q, coef_b_q, coef_c_q, coef_d_q, coef_e_q, coef_f_q;
	logic [31:0]     tex_size_q;
	logic [1:0]      tile_mode_q;
	logic            cfg_wr;
	logic [2:0]      cfg_idx;

	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite;
	assign cfg_idx = paddr[5:3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_a_q    <= '0;
			coef_b_q    <= '0;
			coef_c_q    <= '0;
			coef_d_q    <= '0;
			coef_e_q    <= '0;
			coef_f_q    <= '0;
			tex_size_q  <= TEXSIZE_RESET;
			tile_mode_q <= TILE_CLAMP;
		end else if (cfg_wr) begin
			unique case (cfg_idx)
				REG_COEF_A:  coef_a_q    <= pwdata[PT_W-1:0];
				REG_COEF_B:  coef_b_q    <= pwdata[PT_W-1:0];
				REG_COEF_C:  coef_c_q    <= pwdata[PT_W-1:0];
				REG_COEF_D:  coef_d_q    <= pwdata[PT_W-1:0];
				REG_COEF_E:  coef_e_q    <= pwdata[PT_W-1:0];
				REG_COEF_F:  coef_f_q    <= pwdata[PT_W-1:0];
				REG_TEXSIZE: tex_size_q  <= pwdata[31:0];
				REG_TILE:    tile_mode_q <= pwdata[1:0];
			endcase
		end
	end

	always_comb begin
		unique case (cfg_idx)
			REG_COEF_A:  prdata = {16'd0, coef_a_q};
			REG_COEF_B:  prdata = {16'd0, coef_b_q};
			REG_COEF_C:  prdata = {16'd0, coef_c_q};
			REG_COEF_D:  prdata = {16'd0, coef_d_q};
			REG_COEF_E:  prdata = {16'd0, coef_e_q};
			REG_COEF_F:  prdata = {16'd0, coef_f_q};
			REG_TEXSIZE: prdata = {32'd0, tex_size_q};
			REG_TILE:    prdata = {62'd0, tile_mode_q};
		endcase
	end

	// Texture width and height after the bad-size rules.
	logic [SIZE_W-1:0] w_size, h_size;
	assign w_size = fix_size(tex_size_q[15:0]);
	assign h_size = fix_size(tex_size_q[31:16]);

	// Stage valids and the ready chain. A stage may take new content when it is empty
	// or when its content moves on in the same cycle.
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;
	logic rdy_s1, rdy_s2, rdy_s3, rdy_s4, rdy_s5, rdy_s6;
	logic [CNT_W-1:0] left_q;
	logic [CNT_W-1:0] cnt_s3;
	logic gen_busy, gen_emit, gen_load;

	assign rdy_s6 = !v_s6 || m_tready;
	assign rdy_s5 = !v_s5 || rdy_s6;
	assign rdy_s4 = !v_s4 || rdy_s5;

	// The span generator emits a point whenever pixels are left and stage 4 can take it.
	// It loads the next start point when idle or while it emits the last pixel of a span.
	assign gen_busy = (left_q != '0);
	assign gen_emit = gen_busy && rdy_s4;
	assign gen_load = v_s3 && (!gen_busy || (left_q == CNT_W'(1) && rdy_s4));

	assign rdy_s3 = !v_s3 || gen_load;
	assign rdy_s2 = !v_s2 || rdy_s3;
	assign rdy_s1 = !v_s1 || rdy_s2;
	assign s_tready = rdy_s1;

	logic s_accept;
	assign s_accept = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1   <= 1'b0;
			v_s2   <= 1'b0;
			v_s3   <= 1'b0;
			v_s4   <= 1'b0;
			v_s5   <= 1'b0;
			v_s6   <= 1'b0;
			left_q <= '0;
		end else begin
			if (rdy_s1) v_s1 <= s_tvalid;
			if (rdy_s2) v_s2 <= v_s1;
			if (rdy_s3) v_s3 <= v_s2;
			if (rdy_s4) v_s4 <= gen_busy;
			if (rdy_s5) v_s5 <= v_s4;
			if (rdy_s6) v_s6 <= v_s5;
			if (gen_load) begin
				left_q <= cnt_s3;
			end else if (gen_emit) begin
				left_q <= left_q - CNT_W'(1);
			end
		end
	end

	// Stage 1: capture the request as doubled pixel centers 2x+1, 2y+1 and cut the count.
	logic signed [16:0] x2_s1, y2_s1;
	logic [CNT_W-1:0]   cnt_s1;
	logic [CNT_W-1:0]   req_cnt;

	assign req_cnt = s_tdata[38:32];

	always_ff @(posedge clk) begin
		if (s_accept) begin
			x2_s1  <= {s_tdata[15:0], 1'b1};
			y2_s1  <= {s_tdata[31:16], 1'b1};
			cnt_s1 <= (req_cnt > CNT_W'(MAX_RUN)) ? CNT_W'(MAX_RUN) : req_cnt;
		end
	end

	// Stage 2: the four matrix products. Only their low 49 bits matter, because the
	// doubled sum is halved into a 48-bit point.
	logic signed [PT_W+16:0] mul_au, mul_bu, mul_av, mul_bv;
	logic [PROD_W-1:0]       pau_s2, pbu_s2, pav_s2, pbv_s2;
	logic [CNT_W-1:0]        cnt_s2;

	assign mul_au = $signed(coef_a_q) * x2_s1;
	assign mul_bu = $signed(coef_b_q) * y2_s1;
	assign mul_av = $signed(coef_d_q) * x2_s1;
	assign mul_bv = $signed(coef_e_q) * y2_s1;

	always_ff @(posedge clk) begin
		if (rdy_s2 && v_s1) begin
			pau_s2 <= mul_au[PROD_W-1:0];
			pbu_s2 <= mul_bu[PROD_W-1:0];
			pav_s2 <= mul_av[PROD_W-1:0];
			pbv_s2 <= mul_bv[PROD_W-1:0];
			cnt_s2 <= cnt_s1;
		end
	end

	// Stage 3: add the doubled translation and halve, which gives the start point.
	logic [PROD_W-1:0] sum_u, sum_v;
	logic [PT_W-1:0]   pu_s3, pv_s3;

	assign sum_u = pau_s2 + pbu_s2 + {coef_c_q, 1'b0};
	assign sum_v = pav_s2 + pbv_s2 + {coef_f_q, 1'b0};

	always_ff @(posedge clk) begin
		if (rdy_s3 && v_s2) begin
			pu_s3  <= sum_u[PROD_W-1:1];
			pv_s3  <= sum_v[PROD_W-1:1];
			cnt_s3 <= cnt_s2;
		end
	end

	// Span generator: current point, stepped by the x column of the matrix.
	logic [PT_W-1:0] pu_q, pv_q;

	always_ff @(posedge clk) begin
		if (gen_load) begin
			pu_q <= pu_s3;
			pv_q <= pv_s3;
		end else if (gen_emit) begin
			pu_q <= pu_q + coef_a_q;
			pv_q <= pv_q + coef_d_q;
		end
	end

	// Stage 4: tiling into [0, 1.0].
	logic [T_W-1:0] tu_s4, tv_s4;
	logic           last_s4;

	always_ff @(posedge clk) begin
		if (gen_emit) begin
			tu_s4   <= tile_point(pu_q, tile_mode_q);
			tv_s4   <= tile_point(pv_q, tile_mode_q);
			last_s4 <= (left_q == CNT_W'(1));
		end
	end

	// Stage 5: scale by the texture width and height.
	logic [TP_W-1:0] mu_s5, mv_s5;
	logic            last_s5;

	always_ff @(posedge clk) begin
		if (rdy_s5 && v_s4) begin
			mu_s5   <= TP_W'(tu_s4) * TP_W'(w_size);
			mv_s5   <= TP_W'(tv_s4) * TP_W'(h_size);
			last_s5 <= last_s4;
		end
	end

	// Stage 6: floor, limit to size-1 (the edge at exactly 1.0) and keep 12 bits.
	localparam int FL_W = TP_W - FRAC_BITS;

	logic [FL_W-1:0]   fl_u, fl_v, lim_u, lim_v;
	logic [IDX_W-1:0]  col_s6, row_s6;
	logic              last_s6;

	assign fl_u  = mu_s5[TP_W-1:FRAC_BITS];
	assign fl_v  = mv_s5[TP_W-1:FRAC_BITS];
	assign lim_u = FL_W'(w_size - SIZE_W'(1));
	assign lim_v = FL_W'(h_size - SIZE_W'(1));

	always_ff @(posedge clk) begin
		if (rdy_s6 && v_s5) begin
			col_s6  <= (fl_u > lim_u) ? lim_u[IDX_W-1:0] : fl_u[IDX_W-1:0];
			row_s6  <= (fl_v > lim_v) ? lim_v[IDX_W-1:0] : fl_v[IDX_W-1:0];
			last_s6 <= last_s5;
		end
	end

	assign m_tvalid = v_s6;
	assign m_tdata  = {row_s6, col_s6};
	assign m_tlast  = last_s6;

	// The span counter never holds more than the longest span.
	`ATSG_ASSERT(a_left_bound, left_q <= CNT_W'(MAX_RUN), "span counter above the longest span")
	// Each emitted pixel without a new load takes exactly one off the counter.
	`ATSG_ASSERT_NEXT(a_left_step, gen_emit && !gen_load, left_q == $past(left_q) - CNT_W'(1), "span counter did not step by one")
	// Requests are refused only while the capture stage is occupied.
	`ATSG_ASSERT(a_ready_cause, s_tready || v_s1, "request refused with an empty capture stage")

endmodule

### verif/tb_affine_texel_span_generator_unit.sv
// Self-checking testbench for the affine texel span generator: directed spans, then random setups.
`timescale 1ns / 1ps

module tb_affine_texel_span_generator_unit;
	import atsg_pkg::*;

	// Tile mode 3 is not named by the package; the block treats it as mirror.
	localparam logic [1:0] TILE_SPARE = 2'd3;

	localparam int          FRAC          = FRAC_BITS;
	localparam logic [47:0] UNIT_FX       = 48'd1 << FRAC;
	localparam int          SETTLE_CYCLES = 16;
	localparam int          HOLD_CYCLES   = 400;
	localparam int          STALL_LIMIT   = 3000;
	localparam int          RANDOM_PHASES = 11;
	localparam int          SPANS_PER_PHASE = 19;
	localparam int          PRESSURE_PHASE = 9;
	localparam int          EXTREME_PHASE  = 3;

	typedef struct packed {
		logic [11:0] col;
		logic [11:0] row;
		logic        last;
	} texel_t;

	typedef enum logic {ROW_SPAN, ROW_CFG} row_kind_t;

	// One line of the directed stimulus: either a register write or a span request.
	// A span row with typed set carries its own expected texel for every pixel.
	typedef struct {
		row_kind_t   kind;
		logic [2:0]  reg_idx;
		logic [63:0] value;
		logic [15:0] x;
		logic [15:0] y;
		logic [6:0]  cnt;
		bit          typed;
		logic [11:0] col;
		logic [11:0] row;
	} stim_row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [5:0]  paddr = '0;
	logic [63:0] pwdata = '0;
	logic [63:0] prdata;
	logic        pready;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [39:0] s_tdata = '0;   // start_x [15:0], row_y [31:16], pixel_count [38:32]
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [23:0] m_tdata;        // texel_col [11:0], texel_row [23:12]
	logic        m_tlast;

	// Shadow copy of the configuration, updated at every register write.
	logic [47:0] shadow_coef [6];
	logic [31:0] shadow_size;
	logic [1:0]  shadow_tile;

	texel_t pending_texels [$];
	int     error_count = 0;
	int     tx_idle_pct = 0;
	int     rx_idle_pct = 0;
	int     hold_req = 0;
	int     hold_ack = 0;
	int     hold_left = 0;
	int     stall_cycles = 0;

	affine_texel_span_generator_unit dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Width or height field of the size register as the block uses it: zero reads as one,
	// anything beyond the largest dimension is held at that dimension.
	function automatic logic [12:0] usable_dim(input logic [15:0] raw);
		if (raw == 16'd0) begin
			return 13'd1;
		end else if (raw > 16'(MAX_DIM)) begin
			return 13'(MAX_DIM);
		end
		return raw[12:0];
	endfunction

	// Folds a 48-bit point into [0, 1.0] by the current edge rule, scales it by the
	// dimension and floors it; the index is limited to dim-1 so that 1.0 stays inside.
	function automatic logic [11:0] texel_at(input logic [47:0] p, input logic [12:0] dim);
		logic [47:0] t;
		logic [47:0] folded;
		logic [63:0] idx;
		case (shadow_tile)
			TILE_CLAMP: begin
				if (p[47]) begin
					t = '0;
				end else if (p > UNIT_FX) begin
					t = UNIT_FX;
				end else begin
					t = p;
				end
			end
			TILE_REPEAT: begin
				t = p & (UNIT_FX - 48'd1);
			end
			default: begin
				folded = p & ((UNIT_FX << 1) - 48'd1);
				t = (folded > UNIT_FX) ? (UNIT_FX << 1) - folded : folded;
			end
		endcase
		idx = (64'(t) * 64'(dim)) >> FRAC;
		if (idx > 64'(dim) - 64'd1) begin
			idx = 64'(dim) - 64'd1;
		end
		return idx[11:0];
	endfunction

	function automatic logic [63:0] sext48(input logic [47:0] v);
		return {{16{v[47]}}, v};
	endfunction

	// Maps the first pixel center through the matrix, then walks the span one pixel at a
	// time and queues the texel expected for each. Doubling every term keeps the half
	// pixel offset exact; the final halving is a plain shift of the 64-bit sum.
	function automatic void predict_span(input logic [15:0] x, input logic [15:0] y,
			input logic [6:0] cnt);
		logic [63:0] x2;
		logic [63:0] y2;
		logic [63:0] su;
		logic [63:0] sv;
		logic [47:0] pu;
		logic [47:0] pv;
		logic [12:0] w;
		logic [12:0] h;
		int          n;
		x2 = ({{48{x[15]}}, x} << 1) + 64'd1;
		y2 = ({{48{y[15]}}, y} << 1) + 64'd1;
		su = sext48(shadow_coef[0]) * x2 + sext48(shadow_coef[1]) * y2
			+ (sext48(shadow_coef[2]) << 1);
		sv = sext48(shadow_coef[3]) * x2 + sext48(shadow_coef[4]) * y2
			+ (sext48(shadow_coef[5]) << 1);
		pu = su[48:1];
		pv = sv[48:1];
		w = usable_dim(shadow_size[15:0]);
		h = usable_dim(shadow_size[31:16]);
		n = (cnt > 7'(MAX_RUN)) ? MAX_RUN : int'(cnt);
		for (int k = 0; k < n; k++) begin
			pending_texels.push_back('{texel_at(pu, w), texel_at(pv, h), k == n - 1});
			pu = pu + shadow_coef[0];
			pv = pv + shadow_coef[3];
		end
	endfunction

	function automatic stim_row_t cfg_row(input logic [2:0] idx, input logic [63:0] value);
		stim_row_t r;
		r = '{kind: ROW_CFG, reg_idx: idx, value: value, x: '0, y: '0, cnt: '0,
			typed: 1'b0, col: '0, row: '0};
		return r;
	endfunction

	function automatic stim_row_t span_row(input logic [15:0] x, input logic [15:0] y,
			input logic [6:0] cnt, input bit typed, input logic [11:0] col,
			input logic [11:0] row);
		stim_row_t r;
		r = '{kind: ROW_SPAN, reg_idx: '0, value: '0, x: x, y: y, cnt: cnt,
			typed: typed, col: col, row: row};
		return r;
	endfunction

	// A signed coefficient of random magnitude up to 2**mag_log2, or a raw 48-bit pattern.
	function automatic logic [47:0] rand_coef(input int mag_log2);
		logic [47:0] v;
		if ($urandom_range(5) == 0) begin
			v = 48'({$urandom(), $urandom()});
		end else begin
			v = 48'($urandom_range(0, 32'(1) << mag_log2));
			if ($urandom_range(1) == 1) begin
				v = -v;
			end
		end
		return v;
	endfunction

	// Raw texture dimension field, with zero and oversize values now and then.
	function automatic logic [15:0] rand_dim();
		case ($urandom_range(7))
			0: return 16'd0;
			1: return 16'd1;
			2: return 16'(MAX_DIM);
			3: return 16'($urandom());
			default: return 16'($urandom_range(1, 300));
		endcase
	endfunction

	// Register write over the configuration port: setup cycle and access cycle, then the
	// port is deselected before the task returns so that back-to-back writes never collide.
	task automatic write_reg(input logic [2:0] idx, input logic [63:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 3'b000};
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		case (idx)
			REG_TEXSIZE: shadow_size = value[31:0];
			REG_TILE:    shadow_tile = value[1:0];
			default:     shadow_coef[idx] = value[47:0];
		endcase
		@(posedge clk);
	endtask

	// Offers one span request, with random idle cycles ahead of it, and records the
	// expected texels once the request is accepted. Valid stays high after acceptance
	// so that the next request can follow without a gap.
	task automatic send_span(input logic [15:0] x, input logic [15:0] y, input logic [6:0] cnt,
			input bit typed, input logic [11:0] col, input logic [11:0] row);
		int n;
		while ($urandom_range(99) < tx_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {1'b0, cnt, y, x};
		do begin
			@(posedge clk);
		end while (!s_tready);
		if (typed) begin
			n = (cnt > 7'(MAX_RUN)) ? MAX_RUN : int'(cnt);
			for (int k = 0; k < n; k++) begin
				pending_texels.push_back('{col, row, k == n - 1});
			end
		end else begin
			predict_span(x, y, cnt);
		end
	endtask

	// Stops offering requests and waits until every expected texel has come out. A span
	// of zero pixels yields nothing, so a further settling wait lets such a request leave
	// the pipeline before the configuration may change.
	task automatic drain_spans();
		s_tvalid <= 1'b0;
		while (pending_texels.size() != 0) begin
			@(posedge clk);
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Writes every register with a fresh setup; one phase takes the extremes.
	task automatic setup_phase(input int ph);
		logic [63:0] size_word;
		if (ph == EXTREME_PHASE) begin
			write_reg(REG_COEF_A, sext48(48'h7FFF_FFFF_FFFF));
			write_reg(REG_COEF_B, sext48(48'h8000_0000_0000));
			write_reg(REG_COEF_C, sext48(48'h7FFF_FFFF_FFFF));
			write_reg(REG_COEF_D, sext48(48'h8000_0000_0000));
			write_reg(REG_COEF_E, sext48(48'h0));
			write_reg(REG_COEF_F, sext48(48'h8000_0000_0000));
			write_reg(REG_TEXSIZE, 64'hFFFF_0000);
			write_reg(REG_TILE, 64'(TILE_SPARE));
		end else begin
			write_reg(REG_COEF_A, sext48(rand_coef(20)));
			write_reg(REG_COEF_B, sext48(rand_coef(20)));
			write_reg(REG_COEF_C, sext48(rand_coef(28)));
			write_reg(REG_COEF_D, sext48(rand_coef(20)));
			write_reg(REG_COEF_E, sext48(rand_coef(20)));
			write_reg(REG_COEF_F, sext48(rand_coef(28)));
			size_word = {32'd0, rand_dim(), rand_dim()};
			write_reg(REG_TEXSIZE, size_word);
			write_reg(REG_TILE, 64'($urandom_range(3)));
		end
	endtask

	// Receiver: random ready, plus a long hold-off whenever one is requested. During the
	// hold-off the block fills up and has to stall its request input.
	always @(posedge clk) begin
		if (hold_left > 0) begin
			m_tready  <= 1'b0;
			hold_left <= hold_left - 1;
		end else if (hold_req != hold_ack) begin
			hold_ack  <= hold_req;
			hold_left <= HOLD_CYCLES;
			m_tready  <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(99) >= rx_idle_pct);
		end
	end

	// Every accepted texel is checked against the oldest expectation.
	always @(posedge clk) begin
		texel_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_texels.size() == 0) begin
				$error("texel with no request pending: col %0d row %0d last %0b",
					m_tdata[11:0], m_tdata[23:12], m_tlast);
				error_count++;
			end else begin
				want = pending_texels.pop_front();
				if (m_tdata[11:0] !== want.col) begin
					$error("texel_col: expected %0d, actual %0d", want.col, m_tdata[11:0]);
					error_count++;
				end
				if (m_tdata[23:12] !== want.row) begin
					$error("texel_row: expected %0d, actual %0d", want.row, m_tdata[23:12]);
					error_count++;
				end
				if (m_tlast !== want.last) begin
					$error("last: expected %0b, actual %0b", want.last, m_tlast);
					error_count++;
				end
			end
		end
	end

	// Watchdog: ends the run if nothing moves on any port for too long.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || psel) begin
				stall_cycles <= 0;
			end else if (stall_cycles >= STALL_LIMIT) begin
				$display("[affine_texel_span_generator_unit] ERROR");
				$finish;
			end else begin
				stall_cycles <= stall_cycles + 1;
			end
		end
	end

	initial begin
		stim_row_t   directed_rows [$];
		logic [15:0] x;
		logic [15:0] y;
		logic [6:0]  cnt;
		int          pick;

		for (int i = 0; i < 6; i++) begin
			shadow_coef[i] = '0;
		end
		shadow_size = TEXSIZE_RESET;
		shadow_tile = TILE_CLAMP;

		// After reset the matrix is zero and the texture is 1x1, so every texel is (0, 0).
		directed_rows.push_back(span_row(16'd0, 16'd0, 7'd1, 1'b1, 12'd0, 12'd0));
		directed_rows.push_back(span_row(16'h8000, 16'h7FFF, 7'd3, 1'b1, 12'd0, 12'd0));
		// A zero count gives no texel at all.
		directed_rows.push_back(span_row(16'h7FFF, 16'h8000, 7'd0, 1'b1, 12'd0, 12'd0));
		// A count above the longest span is cut to 64 pixels.
		directed_rows.push_back(span_row(16'h1234, 16'h4321, 7'd127, 1'b1, 12'd0, 12'd0));
		directed_rows.push_back(span_row(16'hFFFF, 16'h0001, 7'd64, 1'b1, 12'd0, 12'd0));
		// u sits exactly at 1.0 and v just below zero on a 4096x4096 texture.
		directed_rows.push_back(cfg_row(REG_COEF_C, 64'h0000_0000_0100_0000));
		directed_rows.push_back(cfg_row(REG_COEF_F, 64'hFFFF_FFFF_FFFF_FFFF));
		directed_rows.push_back(cfg_row(REG_TEXSIZE, 64'h1000_1000));
		directed_rows.push_back(cfg_row(REG_TILE, 64'(TILE_CLAMP)));
		directed_rows.push_back(span_row(16'd5, 16'd7, 7'd2, 1'b1, 12'd4095, 12'd0));
		directed_rows.push_back(cfg_row(REG_TILE, 64'(TILE_MIRROR)));
		directed_rows.push_back(span_row(16'd5, 16'd7, 7'd1, 1'b1, 12'd4095, 12'd0));
		directed_rows.push_back(cfg_row(REG_TILE, 64'(TILE_REPEAT)));
		directed_rows.push_back(span_row(16'd5, 16'd7, 7'd1, 1'b1, 12'd0, 12'd4095));
		// The spare mode behaves as mirror.
		directed_rows.push_back(cfg_row(REG_TILE, 64'(TILE_SPARE)));
		directed_rows.push_back(span_row(16'd5, 16'd7, 7'd1, 1'b1, 12'd4095, 12'd0));
		// A zero width and height act as one, so only texel (0, 0) exists.
		directed_rows.push_back(cfg_row(REG_TEXSIZE, 64'h0000_0000));
		directed_rows.push_back(span_row(16'd5, 16'd7, 7'd1, 1'b1, 12'd0, 12'd0));
		// Oversized dimensions are held at 4096.
		directed_rows.push_back(cfg_row(REG_TEXSIZE, 64'hFFFF_FFFF));
		directed_rows.push_back(span_row(16'd5, 16'd7, 7'd2, 1'b1, 12'd4095, 12'd0));
		// A plain scaled and sheared map over a 64x48 texture, checked by the predictor.
		directed_rows.push_back(cfg_row(REG_COEF_A, sext48(48'd1 << 18)));
		directed_rows.push_back(cfg_row(REG_COEF_B, sext48(48'h3000)));
		directed_rows.push_back(cfg_row(REG_COEF_C, sext48(-(48'd1 << 23))));
		directed_rows.push_back(cfg_row(REG_COEF_D, sext48(-(48'd1 << 17))));
		directed_rows.push_back(cfg_row(REG_COEF_E, sext48(48'd1 << 18)));
		directed_rows.push_back(cfg_row(REG_COEF_F, sext48(48'd1 << 22)));
		directed_rows.push_back(cfg_row(REG_TEXSIZE, 64'h0030_0040));
		directed_rows.push_back(cfg_row(REG_TILE, 64'(TILE_MIRROR)));
		directed_rows.push_back(span_row(16'd0, 16'd0, 7'd64, 1'b0, '0, '0));
		directed_rows.push_back(span_row(-16'sd100, 16'd50, 7'd40, 1'b0, '0, '0));
		directed_rows.push_back(cfg_row(REG_TILE, 64'(TILE_CLAMP)));
		directed_rows.push_back(span_row(-16'sd20, 16'd10, 7'd64, 1'b0, '0, '0));
		directed_rows.push_back(cfg_row(REG_TILE, 64'(TILE_REPEAT)));
		directed_rows.push_back(span_row(16'd100, -16'sd3, 7'd33, 1'b0, '0, '0));
		// Largest coefficients of both signs, where the point arithmetic wraps.
		directed_rows.push_back(cfg_row(REG_COEF_A, sext48(48'h7FFF_FFFF_FFFF)));
		directed_rows.push_back(cfg_row(REG_COEF_B, sext48(48'h8000_0000_0000)));
		directed_rows.push_back(cfg_row(REG_COEF_D, sext48(48'h8000_0000_0000)));
		directed_rows.push_back(cfg_row(REG_COEF_E, sext48(48'h7FFF_FFFF_FFFF)));
		directed_rows.push_back(span_row(16'h7FFF, 16'h7FFF, 7'd10, 1'b0, '0, '0));
		directed_rows.push_back(span_row(16'h8000, 16'h8000, 7'd10, 1'b0, '0, '0));

		tx_idle_pct = 18;
		rx_idle_pct <= 70;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i]) begin
			if (directed_rows[i].kind == ROW_CFG) begin
				drain_spans();
				write_reg(directed_rows[i].reg_idx, directed_rows[i].value);
			end else begin
				send_span(directed_rows[i].x, directed_rows[i].y, directed_rows[i].cnt,
					directed_rows[i].typed, directed_rows[i].col, directed_rows[i].row);
			end
		end
		drain_spans();

		// Random phases: the sender idles lightly and the receiver heavily first, then
		// the other way round, then neither idles. One phase adds a long receiver hold-off.
		for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
			if (ph < 4) begin
				tx_idle_pct = 18;
				rx_idle_pct <= 70;
			end else if (ph < 8) begin
				tx_idle_pct = 70;
				rx_idle_pct <= 18;
			end else begin
				tx_idle_pct = 0;
				rx_idle_pct <= 0;
			end
			setup_phase(ph);
			if (ph == PRESSURE_PHASE) begin
				hold_req <= hold_req + 1;
			end
			for (int i = 0; i < SPANS_PER_PHASE; i++) begin
				pick = $urandom_range(99);
				if (pick < 6) begin
					cnt = 7'd0;
				end else if (pick < 14) begin
					cnt = 7'($urandom_range(65, 127));
				end else if (pick < 30) begin
					cnt = 7'($urandom_range(1, 4));
				end else begin
					cnt = 7'($urandom_range(1, MAX_RUN));
				end
				if ($urandom_range(1) == 0) begin
					x = 16'($urandom());
					y = 16'($urandom());
				end else begin
					x = 16'($urandom_range(0, 400)) - 16'd200;
					y = 16'($urandom_range(0, 400)) - 16'd200;
				end
				send_span(x, y, cnt, 1'b0, '0, '0);
			end
			drain_spans();
		end

		if (error_count == 0) begin
			$display("[affine_texel_span_generator_unit] OK");
		end else begin
			$display("[affine_texel_span_generator_unit] ERROR");
		end
		$finish;
	end

endmodule

### filelist.f
+incdir+rtl
rtl/atsg_pkg.sv
rtl/affine_texel_span_generator_unit.sv
verif/tb_affine_texel_span_generator_unit.sv
